### rtl/tsrb_pkg.sv
// Shared constants and codes of the timestamped sample ring buffer.
package tsrb_pkg;

  // Sample store geometry
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W = 32;

  // Field widths fixed by the channel format
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 11;

  // Longest window a read may return, and the width of its beat counter
  localparam int unsigned MAX_READ = 64;
  localparam int unsigned RLEFT_W  = $clog2(MAX_READ + 1);

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_FILL  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_RESET = 3'd3,
    ACT_SYNC  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXCEEDS    = 3'd1,
    ST_NOT_YET    = 3'd2,
    ST_NOT_ANYMORE = 3'd3,
    ST_TOO_SMALL  = 3'd4,
    ST_TOO_LARGE  = 3'd5
  } status_e;

endpackage

### rtl/tsrb_if.sv
// Valid/ready channel interfaces of the ring buffer: command in, result out, capacity write.
interface tsrb_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         action;
  logic [tsrb_pkg::WORD_W-1:0]        sample_value;
  logic [tsrb_pkg::CNT_W-1:0]         count;
  logic [tsrb_pkg::WORD_W-1:0]        start_index;
  logic signed [tsrb_pkg::WORD_W-1:0] position_value;

  modport source (output valid, action, sample_value, count, start_index, position_value,
                  input ready);
  modport sink   (input valid, action, sample_value, count, start_index, position_value,
                  output ready);
endinterface

interface tsrb_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic [tsrb_pkg::WORD_W-1:0]        read_value;
  logic                               last;
  logic signed [tsrb_pkg::WORD_W-1:0] write_position;
  logic signed [tsrb_pkg::WORD_W-1:0] last_read_position;
  logic                               filled;

  modport source (output valid, status, read_value, last, write_position,
                  last_read_position, filled, input ready);
  modport sink   (input valid, status, read_value, last, write_position,
                  last_read_position, filled, output ready);
endinterface

interface tsrb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tsrb_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/tsrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered, enabled read.
module tsrb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: hold the last word while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/timestamped_sample_ring_buffer_unit.sv
// Top level of the timestamped sample ring buffer: control, position state and sample RAM.
//
//  channel | dir | handshake    | beat carries
//  --------+-----+--------------+----------------------------------------------------------
//  cfg_i   | in  | valid/ready  | data: capacity (0 acts as 1, above DEPTH acts as DEPTH)
//  in_i    | in  | valid/ready  | action, sample_value, count, start_index, position_value
//  out_o   | out | valid/ready  | status, read_value, last, write_position,
//          |     |              | last_read_position, filled
//
// Push, reset, sync and unused codes are answered from idle; a run of zeros is stored
// through the single RAM write port. A read first runs its window checks, then streams
// one sample per cycle through the registered RAM read port while the output takes them.
// Reset is asynchronous and active low; the sample RAM is not cleared and needs no pass.
// The output register frees the input while a result waits; a stalled output holds the
// read stream, and the pending RAM word is kept in the RAM read register.
module timestamped_sample_ring_buffer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsrb_cfg_if.sink   cfg_i,
  tsrb_in_if.sink    in_i,
  tsrb_out_if.source out_o
);

  localparam int unsigned AW  = tsrb_pkg::ADDR_W;
  localparam int unsigned WW  = tsrb_pkg::WORD_W;
  localparam int unsigned CW  = tsrb_pkg::CNT_W;
  localparam int unsigned RW  = tsrb_pkg::RLEFT_W;
  localparam int unsigned SW  = tsrb_pkg::SAMPLE_W;
  localparam int unsigned XW  = WW + 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILL  = 5'b00010,
    S_CHECK = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [WW-1:0]        wc_q, wc_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [WW-1:0]        off_q, off_d;
  logic [WW-1:0]        lri_q, lri_d;
  logic                 filled_q, filled_d;
  logic [CW-1:0]        cap_q;
  logic [CW-1:0]        fill_left_q, fill_left_d;
  logic signed [XW-1:0] start_q, start_d;
  logic [CW-1:0]        rcount_q, rcount_d;
  logic [RW-1:0]        rd_left_q, rd_left_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic                 pend_q, pend_d;
  logic                 pend_last_q, pend_last_d;
  tsrb_pkg::status_e    res_status_q, res_status_d;

  logic                 out_v_q;
  logic [2:0]           out_status_q;
  logic [WW-1:0]        out_value_q;
  logic                 out_last_q;
  logic [WW-1:0]        out_wpos_q;
  logic [WW-1:0]        out_lrpos_q;
  logic                 out_filled_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 consume;
  logic                 rd_issue;
  logic                 store_en;
  logic [SW-1:0]        store_data;
  logic                 emit_now;
  tsrb_pkg::status_e    emit_code;
  logic                 load_res;
  logic [WW-1:0]        wc_inc;
  logic [SW-1:0]        ram_rdata;

  // Window checks on the registered start index
  logic signed [XW-1:0] cap_x, cnt_x, wc_x;
  logic                 chk_too_large, chk_gone, chk_not_yet;
  logic [AW:0]          back_dist, addr_diff;
  logic [AW-1:0]        first_addr;

  // Effective capacity from a written value
  logic [CW-1:0]        cap_eff;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (cfg_i.data == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cfg_i.data) > tsrb_pkg::DEPTH) begin
      cap_eff = CW'(tsrb_pkg::DEPTH);
    end else begin
      cap_eff = cfg_i.data;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_v_q || out_o.ready;
  assign consume    = pend_q && out_free;
  assign rd_issue   = (state_q == S_READ) && (rd_left_q != '0) && (!pend_q || consume);
  assign wc_inc     = wc_q + WW'(1);

  assign cap_x = XW'(cap_q);
  assign cnt_x = XW'(rcount_q);
  assign wc_x  = XW'(wc_q);

  assign chk_too_large = (rcount_q > cap_q) || (32'(rcount_q) > tsrb_pkg::MAX_READ);
  assign chk_gone      = (start_q + cap_x < wc_x) || start_q[XW-1];
  assign chk_not_yet   = (start_q + cnt_x > wc_x);

  // Distance of the first sample behind the write pointer, then its slot
  assign back_dist  = (AW + 1)'(wc_x - start_q);
  assign addr_diff  = {1'b0, wp_q} - back_dist;
  assign first_addr = (back_dist > {1'b0, wp_q}) ? AW'(addr_diff + (AW + 1)'(tsrb_pkg::DEPTH))
                                                 : AW'(addr_diff);

  // Sequence the actions
  always_comb begin
    state_d      = state_q;
    wc_d         = wc_q;
    wp_d         = wp_q;
    off_d        = off_q;
    lri_d        = lri_q;
    filled_d     = filled_q;
    fill_left_d  = fill_left_q;
    start_d      = start_q;
    rcount_d     = rcount_q;
    rd_left_d    = rd_left_q;
    rd_addr_d    = rd_addr_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    res_status_d = res_status_q;
    store_en     = 1'b0;
    store_data   = '0;
    emit_now     = 1'b0;
    emit_code    = tsrb_pkg::ST_OK;
    load_res     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.action)
            tsrb_pkg::ACT_PUSH: begin
              store_en   = 1'b1;
              store_data = SW'(in_i.sample_value);
              emit_now   = 1'b1;
            end
            tsrb_pkg::ACT_FILL: begin
              if (in_i.count > cap_q) begin
                emit_now  = 1'b1;
                emit_code = tsrb_pkg::ST_EXCEEDS;
              end else if (in_i.count == '0) begin
                emit_now = 1'b1;
              end else begin
                fill_left_d = in_i.count;
                state_d     = S_FILL;
              end
            end
            tsrb_pkg::ACT_READ: begin
              start_d  = signed'(XW'(in_i.start_index)) - XW'(signed'(off_q));
              rcount_d = in_i.count;
              state_d  = S_CHECK;
            end
            tsrb_pkg::ACT_RESET: begin
              off_d    = in_i.position_value;
              wc_d     = '0;
              wp_d     = '0;
              lri_d    = '0;
              filled_d = 1'b0;
              emit_now = 1'b1;
            end
            tsrb_pkg::ACT_SYNC: begin
              off_d    = in_i.position_value - wc_q;
              emit_now = 1'b1;
            end
            default: begin
              emit_now = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        store_en    = 1'b1;
        fill_left_d = fill_left_q - CW'(1);
        if (fill_left_q == CW'(1)) begin
          emit_now = 1'b1;
        end
      end
      S_CHECK: begin
        if (rcount_q == '0) begin
          emit_now  = 1'b1;
          emit_code = tsrb_pkg::ST_TOO_SMALL;
        end else if (chk_too_large) begin
          emit_now  = 1'b1;
          emit_code = tsrb_pkg::ST_TOO_LARGE;
        end else if (chk_gone) begin
          emit_now  = 1'b1;
          emit_code = tsrb_pkg::ST_NOT_ANYMORE;
        end else if (chk_not_yet) begin
          emit_now  = 1'b1;
          emit_code = tsrb_pkg::ST_NOT_YET;
        end else begin
          lri_d     = WW'(start_q + cnt_x - XW'(1));
          rd_left_d = RW'(rcount_q);
          rd_addr_d = first_addr;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        // Advance the read stream; retire the pending word when the output takes it
        if (rd_issue) begin
          rd_left_d   = rd_left_q - RW'(1);
          rd_addr_d   = (rd_addr_q == AW'(tsrb_pkg::DEPTH - 1)) ? '0 : rd_addr_q + AW'(1);
          pend_d      = 1'b1;
          pend_last_d = (rd_left_q == RW'(1));
        end else if (consume) begin
          pend_d = 1'b0;
        end
        if (consume && pend_last_q) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        emit_now  = 1'b1;
        emit_code = res_status_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance the write side on each stored sample
    if (store_en) begin
      wp_d     = (wp_q == AW'(tsrb_pkg::DEPTH - 1)) ? '0 : wp_q + AW'(1);
      wc_d     = wc_inc;
      filled_d = filled_q || (wc_inc >= WW'(cap_q));
    end

    // Load the single result now, or hold it until the output frees up
    if (emit_now) begin
      res_status_d = emit_code;
      if (out_free) begin
        load_res = 1'b1;
        state_d  = S_IDLE;
      end else begin
        state_d = S_RESP;
      end
    end
  end

  // Control and position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wc_q         <= '0;
      wp_q         <= '0;
      off_q        <= '0;
      lri_q        <= '0;
      filled_q     <= 1'b0;
      cap_q        <= CW'(tsrb_pkg::DEPTH);
      fill_left_q  <= '0;
      rd_left_q    <= '0;
      rd_addr_q    <= '0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      res_status_q <= tsrb_pkg::ST_OK;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      wc_q         <= wc_d;
      wp_q         <= wp_d;
      off_q        <= off_d;
      lri_q        <= lri_d;
      filled_q     <= filled_d;
      fill_left_q  <= fill_left_d;
      rd_left_q    <= rd_left_d;
      rd_addr_q    <= rd_addr_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      res_status_q <= res_status_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cap_eff;
      end
      if (load_res || consume) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Read command payload
  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    rcount_q <= rcount_d;
  end

  // Output register: single results and streamed samples
  always_ff @(posedge clk_i) begin
    if (load_res || consume) begin
      out_wpos_q   <= off_d + wc_d;
      out_lrpos_q  <= off_d + lri_d;
      out_filled_q <= filled_d;
      if (load_res) begin
        out_status_q <= res_status_d;
        out_value_q  <= '0;
        out_last_q   <= 1'b1;
      end else begin
        out_status_q <= tsrb_pkg::ST_OK;
        out_value_q  <= WW'(ram_rdata);
        out_last_q   <= pend_last_q;
      end
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.status             = out_status_q;
  assign out_o.read_value         = out_value_q;
  assign out_o.last               = out_last_q;
  assign out_o.write_position     = out_wpos_q;
  assign out_o.last_read_position = out_lrpos_q;
  assign out_o.filled             = out_filled_q;

  tsrb_ram #(
    .Width (SW),
    .Depth (tsrb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (wp_q),
    .wdata_i (store_data),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // A pending RAM word that the output cannot take is never replaced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !consume) |-> !rd_issue)
    else $error("read issued over an untaken sample");

  // Writes and reads of the sample RAM never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_en && rd_issue))
    else $error("sample RAM written and read together");

  // The final sample beat of a window returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && consume && pend_last_q) |=> (state_q == S_IDLE && !pend_q))
    else $error("read stream did not close after its last beat");

  // Only a reset action clears the filled flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q && !(in_acc && in_i.action == tsrb_pkg::ACT_RESET)) |=> filled_q)
    else $error("filled flag dropped without a reset action");

endmodule

### tb/timestamped_sample_ring_buffer_unit_tb.sv
// Self-checking testbench of the timestamped sample ring buffer: predicted beats vs. DUT.
`timescale 1ns / 100ps

module timestamped_sample_ring_buffer_unit_tb;

  localparam int unsigned WW = tsrb_pkg::WORD_W;
  localparam int unsigned CW = tsrb_pkg::CNT_W;
  localparam int unsigned AW = tsrb_pkg::ADDR_W;

  localparam int unsigned STUCK_LIMIT = 5000;  // cycles without any handshake
  localparam int unsigned LONG_HOLD   = 300;   // receiver hold-off that backs up the block
  localparam logic [2:0]  ACT_SPARE_LO = 3'd5;  // first code with no action behind it
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]    action;
    logic [WW-1:0] sample;
    logic [CW-1:0] count;
    logic [WW-1:0] start;
    logic [WW-1:0] pos;
  } ring_cmd_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [WW-1:0] value;
    logic          last_flag;
    logic [WW-1:0] wpos;
    logic [WW-1:0] rpos;
    logic          filled;
  } ring_beat_t;

  logic clk_i;
  logic rst_ni;

  tsrb_cfg_if cfg_if ();
  tsrb_in_if  in_if ();
  tsrb_out_if out_if ();

  timestamped_sample_ring_buffer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Commands waiting for the driver, beats waiting for the DUT
  ring_cmd_t  cmd_queue[$];
  ring_beat_t expected_beats[$];

  // Predicted ring state
  logic [tsrb_pkg::SAMPLE_W-1:0] mdl_store [tsrb_pkg::DEPTH];
  logic [WW-1:0]                 mdl_count;
  logic [AW-1:0]                 mdl_wptr;
  logic [WW-1:0]                 mdl_offset;
  logic [WW-1:0]                 mdl_last_rd;
  logic                          mdl_filled;
  logic [CW-1:0]                 mdl_cap_reg;

  // Shadow of the write position as commands are queued, used to aim reads
  logic [WW-1:0] plan_count;
  logic [WW-1:0] plan_offset;
  int unsigned   plan_cap;

  logic        in_took;
  logic        no_idle;
  logic        hold_req;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned stuck_cycles;
  int unsigned mismatches;
  ring_cmd_t   next_cmd;
  ring_beat_t  got;
  ring_beat_t  want;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_capacity(input logic [CW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > tsrb_pkg::DEPTH) return tsrb_pkg::DEPTH;
    return raw;
  endfunction

  // Queue one beat carrying the position state after the command
  function automatic void queue_beat(input tsrb_pkg::status_e st, input logic [WW-1:0] v,
                                     input logic lst);
    expected_beats.push_back(ring_beat_t'{status: st, value: v, last_flag: lst,
                                          wpos: mdl_offset + mdl_count,
                                          rpos: mdl_offset + mdl_last_rd,
                                          filled: mdl_filled});
  endfunction

  function automatic void store_word(input logic [tsrb_pkg::SAMPLE_W-1:0] v);
    mdl_store[mdl_wptr] = v;
    mdl_wptr = mdl_wptr + 1'b1;
    mdl_count = mdl_count + 1;
    if (!mdl_filled && mdl_count >= eff_capacity(mdl_cap_reg)) mdl_filled = 1'b1;
  endfunction

  // Advance the predicted ring by one accepted command and queue its beats
  function automatic void apply_command(input ring_cmd_t c);
    longint        capl;
    longint        n;
    longint        first;
    longint        avail;
    logic [WW-1:0] back_dist;
    logic [AW-1:0] addr;
    capl = eff_capacity(mdl_cap_reg);
    n = c.count;
    case (c.action)
      tsrb_pkg::ACT_PUSH: begin
        store_word(c.sample);
        queue_beat(tsrb_pkg::ST_OK, '0, 1'b1);
      end
      tsrb_pkg::ACT_FILL: begin
        if (n > capl) begin
          queue_beat(tsrb_pkg::ST_EXCEEDS, '0, 1'b1);
        end else begin
          for (longint i = 0; i < n; i++) store_word('0);
          queue_beat(tsrb_pkg::ST_OK, '0, 1'b1);
        end
      end
      tsrb_pkg::ACT_READ: begin
        first = $signed({32'd0, c.start}) - $signed({{32{mdl_offset[31]}}, mdl_offset});
        avail = {32'd0, mdl_count};
        if (n == 0) begin
          queue_beat(tsrb_pkg::ST_TOO_SMALL, '0, 1'b1);
        end else if (n > capl || n > tsrb_pkg::MAX_READ) begin
          queue_beat(tsrb_pkg::ST_TOO_LARGE, '0, 1'b1);
        end else if (first + capl < avail || first < 0) begin
          queue_beat(tsrb_pkg::ST_NOT_ANYMORE, '0, 1'b1);
        end else if (first + n > avail) begin
          queue_beat(tsrb_pkg::ST_NOT_YET, '0, 1'b1);
        end else begin
          mdl_last_rd = WW'(first + n - 1);
          // walk back from the write pointer by the distance of each sample
          for (longint i = 0; i < n; i++) begin
            back_dist = WW'(avail - (first + i));
            addr = mdl_wptr - back_dist[AW-1:0];
            queue_beat(tsrb_pkg::ST_OK, mdl_store[addr], i == n - 1);
          end
        end
      end
      tsrb_pkg::ACT_RESET: begin
        mdl_offset = c.pos;
        mdl_count = '0;
        mdl_wptr = '0;
        mdl_last_rd = '0;
        mdl_filled = 1'b0;
        queue_beat(tsrb_pkg::ST_OK, '0, 1'b1);
      end
      tsrb_pkg::ACT_SYNC: begin
        mdl_offset = c.pos - mdl_count;
        queue_beat(tsrb_pkg::ST_OK, '0, 1'b1);
      end
      default: queue_beat(tsrb_pkg::ST_OK, '0, 1'b1);
    endcase
  endfunction

  // Queue a command and track where the write position will be
  function automatic void send(input logic [2:0] act, input logic [CW-1:0] n,
                               input logic [WW-1:0] st, input logic [WW-1:0] pos,
                               input logic [WW-1:0] word);
    cmd_queue.push_back(ring_cmd_t'{action: act, sample: word, count: n, start: st, pos: pos});
    case (act)
      tsrb_pkg::ACT_PUSH:  plan_count = plan_count + 1;
      tsrb_pkg::ACT_FILL:  if (n <= plan_cap) plan_count = plan_count + n;
      tsrb_pkg::ACT_RESET: begin
        plan_offset = pos;
        plan_count = '0;
      end
      tsrb_pkg::ACT_SYNC:  plan_offset = pos - plan_count;
      default:   ;
    endcase
  endfunction

  // Mostly pushes and reads aimed at the live window; the rest error cases and noise
  function automatic void random_command();
    ring_cmd_t   c;
    int unsigned pick;
    int unsigned span;
    int unsigned lim;
    int unsigned n;
    int unsigned back;
    c = ring_cmd_t'{action: tsrb_pkg::ACT_PUSH, sample: $urandom(),
                    count: CW'($urandom_range(0, 1024)),
                    start: $urandom(), pos: $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.action = tsrb_pkg::ACT_PUSH;
    end else if (pick < 55) begin
      c.action = tsrb_pkg::ACT_FILL;
      if ($urandom_range(0, 3) == 0 && plan_cap < tsrb_pkg::DEPTH)
        c.count = CW'(plan_cap + 1 + $urandom_range(0, 2));
      else
        c.count = CW'($urandom_range(0, (plan_cap < 6) ? plan_cap : 6));
    end else if (pick < 85) begin
      c.action = tsrb_pkg::ACT_READ;
      if (plan_count != 0 && $urandom_range(0, 4) != 0) begin
        span = (plan_count < plan_cap) ? plan_count : plan_cap;
        lim = (span < tsrb_pkg::MAX_READ) ? span : tsrb_pkg::MAX_READ;
        n = $urandom_range(1, lim);
        back = $urandom_range(0, span - n);
        c.count = CW'(n);
        c.start = plan_offset + plan_count - n - back;
      end else begin
        case ($urandom_range(0, 3))
          0: c.count = '0;
          1: c.count = CW'($urandom_range(tsrb_pkg::MAX_READ + 1, 1024));
          2: begin
            c.count = CW'($urandom_range(1, 4));
            c.start = plan_offset + plan_count - c.count + 1 + $urandom_range(0, 3);
          end
          default: begin
            c.count = CW'($urandom_range(1, 3));
            c.start = plan_offset - $urandom_range(1, 4);
          end
        endcase
      end
    end else if (pick < 93) begin
      c.action = tsrb_pkg::ACT_SYNC;
      if ($urandom_range(0, 3) != 0) c.pos = $urandom_range(0, 100000);
    end else if (pick < 98) begin
      c.action = tsrb_pkg::ACT_RESET;
      if ($urandom_range(0, 3) != 0) c.pos = $urandom_range(0, 100000);
    end else begin
      c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    send(c.action, c.count, c.start, c.pos, c.sample);
  endfunction

  // Wait until every command is taken and every beat has come back, then let the block rest
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (cmd_queue.size() != 0 || in_if.valid || expected_beats.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CW-1:0] raw);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= raw;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    plan_cap = eff_capacity(raw);
  endtask

  // Command driver: hold a beat until taken, idle in short bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && !in_took) begin
        // keep the beat on the bus
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (cmd_queue.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        in_if.valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        next_cmd = cmd_queue.pop_front();
        in_if.valid          <= 1'b1;
        in_if.action         <= next_cmd.action;
        in_if.sample_value   <= next_cmd.sample;
        in_if.count          <= next_cmd.count;
        in_if.start_index    <= next_cmd.start;
        in_if.position_value <= next_cmd.pos;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall in short bursts, once for a long stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check result beats, track capacity writes, predict accepted commands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took = in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        got = {out_if.status, out_if.read_value, out_if.last, out_if.write_position,
               out_if.last_read_position, out_if.filled};
        if (expected_beats.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected beat: st=%0d val=%h last=%b wpos=%h rpos=%h fill=%b",
                     got.status, got.value, got.last_flag, got.wpos, got.rpos, got.filled);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("mismatch: want st=%0d val=%h last=%b wpos=%h rpos=%h fill=%b",
                       want.status, want.value, want.last_flag, want.wpos, want.rpos,
                       want.filled);
              $display("          got  st=%0d val=%h last=%b wpos=%h rpos=%h fill=%b",
                       got.status, got.value, got.last_flag, got.wpos, got.rpos,
                       got.filled);
            end
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) mdl_cap_reg = cfg_if.data;
      if (in_took)
        apply_command({in_if.action, in_if.sample_value, in_if.count, in_if.start_index,
                       in_if.position_value});
      // Watchdog on handshake activity
      if (in_took || (out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = '0;
    in_if.sample_value = '0;
    in_if.count = '0;
    in_if.start_index = '0;
    in_if.position_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_took = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    gap_left = 0;
    stall_left = 0;
    stuck_cycles = 0;
    mismatches = 0;
    mdl_count = '0;
    mdl_wptr = '0;
    mdl_offset = '0;
    mdl_last_rd = '0;
    mdl_filled = 1'b0;
    mdl_cap_reg = CW'(tsrb_pkg::DEPTH);
    plan_count = '0;
    plan_offset = '0;
    plan_cap = tsrb_pkg::DEPTH;

    // Directed: empty ring, size errors, field extremes, sync and reset offsets
    send(tsrb_pkg::ACT_READ, 11'd1, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd0, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd65, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd1024, 32'hFFFF_FFFF, '0, '0);
    send(tsrb_pkg::ACT_FILL, 11'd0, '0, '0, '0);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'h0000_0000);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'hFFFF_FFFF);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'hA5A5_5A5A);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'h8000_0001);
    send(tsrb_pkg::ACT_READ, 11'd4, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd2, 32'd3, '0, '0);
    send(tsrb_pkg::ACT_FILL, 11'd3, '0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd5, 32'd2, '0, '0);
    send(tsrb_pkg::ACT_SYNC, '0, '0, 32'd100, '0);
    send(tsrb_pkg::ACT_READ, 11'd7, 32'd93, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd1, 32'd92, '0, '0);
    send(ACT_SPARE_LO, 11'h7FF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_SPARE_HI, '0, '0, '0, '0);
    send(tsrb_pkg::ACT_RESET, '0, '0, 32'h7FFF_FFF0, '0);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'h1234_5678);
    send(tsrb_pkg::ACT_PUSH, '0, '0, '0, 32'h0F0F_F0F0);
    send(tsrb_pkg::ACT_READ, 11'd1, 32'h7FFF_FFF1, '0, '0);
    send(tsrb_pkg::ACT_RESET, '0, '0, 32'h8000_0000, '0);
    send(tsrb_pkg::ACT_SYNC, '0, '0, 32'hFFFF_FFFF, '0);
    send(tsrb_pkg::ACT_RESET, '0, '0, 32'd0, '0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    settle();

    // Small ring; hold the receiver off so the block backs up
    write_capacity(11'd8);
    hold_req = 1'b1;
    for (int k = 0; k < 10; k++) send(tsrb_pkg::ACT_PUSH, '0, '0, '0, $urandom());
    send(tsrb_pkg::ACT_FILL, 11'd9, '0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd9, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd1, 32'd0, '0, '0);
    send(tsrb_pkg::ACT_READ, 11'd8, 32'd2, '0, '0);
    for (int k = 0; k < 10; k++) random_command();
    settle();

    // Capacity zero acts as a single slot
    write_capacity(11'd0);
    for (int k = 0; k < 8; k++) random_command();
    settle();

    // All register bits set: acts as full depth; one full-depth fill
    write_capacity(11'h7FF);
    send(tsrb_pkg::ACT_FILL, 11'd1024, '0, '0, '0);
    for (int k = 0; k < 8; k++) random_command();
    settle();

    write_capacity(11'd1025);
    for (int k = 0; k < 6; k++) random_command();
    settle();

    write_capacity(11'd64);
    for (int k = 0; k < 10; k++) random_command();
    settle();

    write_capacity(11'd1);
    for (int k = 0; k < 6; k++) random_command();
    settle();

    // Full depth at full rate: wrap the write pointer and read across it
    write_capacity(11'd1024);
    no_idle = 1'b1;
    send(tsrb_pkg::ACT_FILL, 11'd1024, '0, '0, '0);
    for (int k = 0; k < 23; k++) random_command();
    settle();
    repeat (24) @(posedge clk_i);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
